FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Plain invariant.
`define TCPD_ASSERT_INV(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

FILE: design/tcpd_pkg.sv
// ----------------------------------------------------------------------------
// Turnout coil pulse driver package
// Types, codes and constants shared by the driver modules.
// ----------------------------------------------------------------------------
package tcpd_pkg;

    localparam int DUR_W             = 16;
    localparam int ACK_W             = 4;
    localparam int ACK_TICKS_MAX_DEF = 10;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SET       = 3'd1,
        OP_TOGGLE    = 3'd2,
        OP_ACK_PULSE = 3'd3,
        OP_ACK_OFF   = 3'd4,
        OP_CLR_ACK   = 3'd5
    } t_op;

    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_CLOSE  = 2'd1;
    localparam logic [1:0] DIR_THROWN = 2'd2;

    // bit positions in the drive level vector
    localparam int LVL_A  = 0;
    localparam int LVL_B  = 1;
    localparam int LVL_EN = 2;

    localparam logic CFG_REVERSE_POLARITY = 1'b0;
    localparam logic CFG_TURN_ON_DELAY    = 1'b1;

    typedef struct packed {
        logic [2:0]       operation;
        logic [1:0]       direction;
        logic [DUR_W-1:0] duration;
        logic             lock_active;
    } t_item;

    typedef struct packed {
        logic coil_a;
        logic coil_b;
        logic enable;
        logic ack_flag;
        logic last_thrown;
        logic waiting;
    } t_result;

    typedef struct packed {
        logic             reverse_polarity;
        logic [DUR_W-1:0] turn_on_delay;
    } t_cfg;

endpackage

FILE: design/tcpd_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command or tick request.
// ----------------------------------------------------------------------------
interface tcpd_cmd_if import tcpd_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [2:0]       operation;
    logic [1:0]       direction;
    logic [DUR_W-1:0] duration;
    logic             lock_active;

    modport source (output valid, operation, direction, duration, lock_active,
                    input ready);
    modport sink   (input valid, operation, direction, duration, lock_active,
                    output ready);
endinterface

FILE: design/tcpd_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the output levels after each request.
// ----------------------------------------------------------------------------
interface tcpd_res_if;
    logic valid;
    logic ready;
    logic coil_a;
    logic coil_b;
    logic enable;
    logic ack_flag;
    logic last_thrown;
    logic waiting;

    modport source (output valid, coil_a, coil_b, enable, ack_flag, last_thrown,
                    waiting, input ready);
    modport sink   (input valid, coil_a, coil_b, enable, ack_flag, last_thrown,
                    waiting, output ready);
endinterface

FILE: design/tcpd_core.sv
// ----------------------------------------------------------------------------
// Turnout driver state core
// Holds counters and levels; applies one request per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcpd_core import tcpd_pkg::*; #(
    parameter int ACK_TICKS_MAX = ACK_TICKS_MAX_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam logic [ACK_W-1:0] ACK_END = ACK_W'(ACK_TICKS_MAX);

    logic [DUR_W-1:0] r_pulse, n_pulse;
    logic [DUR_W-1:0] r_delay, n_delay;
    logic [1:0]       r_pend_dir, n_pend_dir;
    logic [DUR_W-1:0] r_pend_dur, n_pend_dur;
    logic [ACK_W-1:0] r_ack, n_ack;
    logic             r_sticky, n_sticky;
    logic             r_thrown, n_thrown;
    logic [2:0]       r_levels, n_levels;

    logic             s_req;
    logic [1:0]       s_dir;
    logic [DUR_W-1:0] s_dur;
    logic             s_lock;
    logic [ACK_W-1:0] ack_inc;

    assign ack_inc = r_ack + 1'b1;

    always_comb begin
        n_pulse    = r_pulse;
        n_delay    = r_delay;
        n_pend_dir = r_pend_dir;
        n_pend_dur = r_pend_dur;
        n_ack      = r_ack;
        n_sticky   = r_sticky;
        n_thrown   = r_thrown;
        n_levels   = r_levels;
        s_req      = 1'b0;
        s_dir      = i_item.direction;
        s_dur      = i_item.duration;
        s_lock     = i_item.lock_active;

        unique case (t_op'(i_item.operation))
            OP_TICK: begin
                if (r_ack != '0) begin
                    n_ack = ack_inc;
                    if (ack_inc >= ACK_END || ack_inc == '0) begin
                        n_ack    = '0;
                        n_levels = '0;
                    end
                end else if (r_delay != '0) begin
                    n_delay = r_delay - 1'b1;
                    if (r_delay == DUR_W'(1)) begin
                        n_levels[LVL_EN] = 1'b1;
                    end
                end else begin
                    if (r_pulse != '0) begin
                        n_pulse = r_pulse - 1'b1;
                    end
                    // count reaches (or sits at) zero
                    if (r_pulse <= DUR_W'(1)) begin
                        n_levels = '0;
                    end
                    // retry a held set or toggle once the lock is released
                    if (r_pend_dir != DIR_NONE && !i_item.lock_active) begin
                        n_pend_dir = DIR_NONE;
                        n_pend_dur = '0;
                        s_req      = 1'b1;
                        s_dir      = r_pend_dir;
                        s_dur      = r_pend_dur;
                        s_lock     = 1'b0;
                    end
                end
            end
            OP_SET: begin
                s_req = 1'b1;
            end
            OP_TOGGLE: begin
                s_req = 1'b1;
                s_dir = r_thrown ? DIR_CLOSE : DIR_THROWN;
            end
            OP_ACK_PULSE: begin
                n_ack            = ACK_W'(1);
                n_sticky         = 1'b1;
                n_levels         = '0;
                n_levels[LVL_A]  = 1'b1;
                n_levels[LVL_EN] = 1'b1;
            end
            OP_ACK_OFF: begin
                n_ack    = '0;
                n_levels = '0;
            end
            OP_CLR_ACK: begin
                n_sticky = 1'b0;
            end
            default: begin
            end
        endcase

        if (s_req) begin
            if (s_lock) begin
                n_pend_dir = s_dir;
                n_pend_dur = s_dur;
            end else begin
                n_levels = '0;
                if (s_dir == DIR_CLOSE) begin
                    n_levels[i_cfg.reverse_polarity ? LVL_A : LVL_B] = 1'b1;
                    n_thrown = 1'b0;
                end else if (s_dir == DIR_THROWN) begin
                    n_levels[i_cfg.reverse_polarity ? LVL_B : LVL_A] = 1'b1;
                    n_thrown = 1'b1;
                end
                n_delay = i_cfg.turn_on_delay;
                if (i_cfg.turn_on_delay == '0) begin
                    n_levels[LVL_EN] = 1'b1;
                end
                n_pulse = s_dur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse    <= '0;
            r_delay    <= '0;
            r_pend_dir <= DIR_NONE;
            r_pend_dur <= '0;
            r_ack      <= '0;
            r_sticky   <= 1'b0;
            r_thrown   <= 1'b0;
            r_levels   <= '0;
        end else if (i_step) begin
            r_pulse    <= n_pulse;
            r_delay    <= n_delay;
            r_pend_dir <= n_pend_dir;
            r_pend_dur <= n_pend_dur;
            r_ack      <= n_ack;
            r_sticky   <= n_sticky;
            r_thrown   <= n_thrown;
            r_levels   <= n_levels;
        end
    end

    // levels after this request
    assign o_res.coil_a      = n_levels[LVL_A];
    assign o_res.coil_b      = n_levels[LVL_B];
    assign o_res.enable      = n_levels[LVL_EN];
    assign o_res.ack_flag    = n_sticky;
    assign o_res.last_thrown = n_thrown;
    assign o_res.waiting     = (n_pend_dir != DIR_NONE);

    `TCPD_ASSERT_INV(a_ack_bound, i_clk, i_rst_n, r_ack < ACK_END,
        "ack tick counter passed its end count")
    `TCPD_ASSERT_NXT(a_ack_sticky, i_clk, i_rst_n,
        i_step && i_item.operation == OP_ACK_PULSE, r_sticky,
        "ack pulse did not set the sticky flag")
    `TCPD_ASSERT_NXT(a_ack_tick_hold, i_clk, i_rst_n,
        i_step && i_item.operation == OP_TICK && r_ack != '0,
        $stable(r_pulse) && $stable(r_delay) && $stable(r_pend_dir),
        "tick during ack pulse touched pulse, delay or held command")
    `TCPD_ASSERT_NXT(a_locked_set_hold, i_clk, i_rst_n,
        i_step && i_item.operation == OP_SET && i_item.lock_active,
        $stable(r_levels) && $stable(r_pulse),
        "locked set changed the drive")

endmodule

FILE: design/turnout_coil_pulse_driver_unit.sv
// ----------------------------------------------------------------------------
// Turnout coil pulse driver unit
// Two-coil point motor driver with lock hold, ack pulse and turn-on delay.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd  : request channel (valid/ready). Each request is a tick or a
//            command: set, toggle, ack pulse, ack off, clear ack flag.
//   o_res  : one result per request, the coil/enable levels and status
//            flags as they stand after that request, in request order.
//   i_cfg_*: write port for reverse_polarity (index 0) and turn_on_delay
//            (index 1); write only while no request is in flight.
// Path: a request accepted into the input register goes through the state
//   update into the result register and shows on o_res from there.
// Throughput: one request per cycle while o_res.ready is high; the state
//   update is a single pass of counter and mux logic, so i_cmd.ready stays high.
// Stall: when o_res.ready is low the result register holds, the input
//   register fills, and i_cmd.ready then drops until the result is taken.
// Reset: synchronous, active low; all counters, levels, flags, held
//   command and both config registers go to zero, both channels empty.
// ----------------------------------------------------------------------------
module turnout_coil_pulse_driver_unit import tcpd_pkg::*; #(
    parameter int ACK_TICKS_MAX = ACK_TICKS_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcpd_cmd_if.sink         i_cmd,
    tcpd_res_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [DUR_W-1:0] i_cfg_data
);

    // config registers
    t_cfg    r_cfg;

    // input stage
    logic    r_s1_valid;
    t_item   r_s1_item;

    // result stage
    logic    r_out_valid;
    t_result r_out_res;

    logic    out_adv;   // result register can load
    logic    step;      // input stage item goes through the core
    logic    in_acc;    // request accepted
    t_result core_res;

    assign out_adv     = !r_out_valid || o_res.ready;
    assign step        = r_s1_valid && out_adv;
    assign i_cmd.ready = !r_s1_valid || out_adv;
    assign in_acc      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REVERSE_POLARITY: r_cfg.reverse_polarity <= i_cfg_data[0];
                CFG_TURN_ON_DELAY:    r_cfg.turn_on_delay    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (out_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item.operation   <= i_cmd.operation;
            r_s1_item.direction   <= i_cmd.direction;
            r_s1_item.duration    <= i_cmd.duration;
            r_s1_item.lock_active <= i_cmd.lock_active;
        end
    end

    tcpd_core #(
        .ACK_TICKS_MAX(ACK_TICKS_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_s1_item),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= core_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.coil_a      = r_out_res.coil_a;
    assign o_res.coil_b      = r_out_res.coil_b;
    assign o_res.enable      = r_out_res.enable;
    assign o_res.ack_flag    = r_out_res.ack_flag;
    assign o_res.last_thrown = r_out_res.last_thrown;
    assign o_res.waiting     = r_out_res.waiting;

endmodule
